>>> hw/rtl/bli_pkg.sv
// ----------------------------------------------------------------------------
// bli_pkg
// Shared widths, defaults and types of the beam linear interpolator.
// ----------------------------------------------------------------------------
package bli_pkg;

  localparam int unsigned PIX_W             = 8;
  localparam int unsigned FACTOR_W          = 5;
  localparam int unsigned MAX_EXPANSION_DEF = 16;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(4);

  // Result of one pixel-difference division by the factor
  typedef struct packed {
    logic [PIX_W-1:0]    quot;
    logic [FACTOR_W-1:0] rem;
  } div_res_t;

endpackage

>>> hw/rtl/beam_linear_interpolator.sv
// ----------------------------------------------------------------------------
// beam_linear_interpolator
// Widens rows of 8-bit beam samples by factor E with linear interpolation.
// ----------------------------------------------------------------------------
// A request with a pixel held divides the pixel difference by E bit-serially,
//   then sets up and gives a run of E results, one per cycle unless stalled;
//   no new request is taken until done. A row end with a pixel held adds a
//   repeat run, a one-pixel row gives only that run, a pixel only held none.
// Reset: factor 4, no pixel held, output empty.
module beam_linear_interpolator
  import bli_pkg::*;
#(
  parameter int unsigned MAX_EXPANSION = MAX_EXPANSION_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: expansion factor
  input  logic                cfg_we_i,
  input  logic [FACTOR_W-1:0] cfg_wdata_i,
  // input requests
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PIX_W-1:0]    pixel_value_i,
  input  logic                row_end_i,
  input  logic                frame_end_i,
  // output results
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PIX_W-1:0]    out_pixel_o,
  output logic                run_last_o,
  output logic                out_row_end_o,
  output logic                out_frame_end_o
);

  // Cap compared one bit wider than the register so a cap of 32 still fits
  localparam logic [FACTOR_W:0] MAX_E = (FACTOR_W+1)'(MAX_EXPANSION);

  logic [FACTOR_W-1:0] factor_q;
  logic [FACTOR_W-1:0] factor_eff;

  logic             div_start;
  logic [PIX_W-1:0] div_dividend;
  logic             div_done;
  div_res_t         div_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_RESET;
    end else if (cfg_we_i) begin
      factor_q <= cfg_wdata_i;
    end
  end

  // zero acts as one; anything above the cap saturates
  always_comb begin
    if (factor_q == '0) begin
      factor_eff = FACTOR_W'(1);
    end else if ({1'b0, factor_q} > MAX_E) begin
      factor_eff = MAX_E[FACTOR_W-1:0];
    end else begin
      factor_eff = factor_q;
    end
  end

  // Divides |b - a| by E once per interpolated run; the sequencer then walks
  // the run with a quotient/remainder accumulator, one result per cycle while the output is not stalled.
  bli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (factor_eff),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  bli_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .factor_i        (factor_eff),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pixel_value_i   (pixel_value_i),
    .row_end_i       (row_end_i),
    .frame_end_i     (frame_end_i),
    .div_start_o     (div_start),
    .div_dividend_o  (div_dividend),
    .div_done_i      (div_done),
    .div_res_i       (div_res),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_pixel_o     (out_pixel_o),
    .run_last_o      (run_last_o),
    .out_row_end_o   (out_row_end_o),
    .out_frame_end_o (out_frame_end_o)
  );

endmodule

>>> hw/rtl/bli_div.sv
// ----------------------------------------------------------------------------
// bli_div
// Restoring divider, one quotient bit per cycle through a single subtractor.
// ----------------------------------------------------------------------------
module bli_div
  import bli_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [PIX_W-1:0]    dividend_i,
  input  logic [FACTOR_W-1:0] divisor_i,
  output logic                done_o,
  output div_res_t            res_o
);

  localparam int unsigned CNT_W = $clog2(PIX_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PIX_W - 1);

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [PIX_W-1:0]    num_q;
  logic [PIX_W-1:0]    quot_q;
  logic [FACTOR_W-1:0] rem_q;
  logic [FACTOR_W-1:0] divisor_q;

  logic [FACTOR_W:0]   trial;
  logic                fits;
  logic [FACTOR_W:0]   diff;
  logic [FACTOR_W-1:0] rem_d;

  // shared compare / subtract
  always_comb begin
    trial = {rem_q, num_q[PIX_W-1]};
    diff  = trial - {1'b0, divisor_q};
    fits  = (trial >= {1'b0, divisor_q});
    rem_d = fits ? diff[FACTOR_W-1:0] : trial[FACTOR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done_q <= busy_q && !start_i && (cnt_q == LAST_STEP);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q     <= dividend_i;
      quot_q    <= '0;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      num_q  <= {num_q[PIX_W-2:0], 1'b0};
      quot_q <= {quot_q[PIX_W-2:0], fits};
      rem_q  <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

>>> hw/rtl/bli_ctrl.sv
// ----------------------------------------------------------------------------
// bli_ctrl
// Sequencer: holds the left pixel, runs the divider, steps the interpolation
// accumulator and drives the output register.
// ----------------------------------------------------------------------------
module bli_ctrl
  import bli_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [FACTOR_W-1:0] factor_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PIX_W-1:0]    pixel_value_i,
  input  logic                row_end_i,
  input  logic                frame_end_i,
  output logic                div_start_o,
  output logic [PIX_W-1:0]    div_dividend_o,
  input  logic                div_done_i,
  input  div_res_t            div_res_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PIX_W-1:0]    out_pixel_o,
  output logic                run_last_o,
  output logic                out_row_end_o,
  output logic                out_frame_end_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_INTERP,
    ST_REPEAT
  } state_e;

  state_e              state_q;
  logic [PIX_W-1:0]    held_q;
  logic                held_valid_q;
  logic [PIX_W-1:0]    pix_q;
  logic                row_last_q;
  logic                frame_last_q;
  logic                neg_q;
  logic signed [PIX_W:0] qd_q;
  logic [FACTOR_W-1:0] rd_q;
  logic [PIX_W-1:0]    q_q;
  logic [FACTOR_W-1:0] r_q;
  logic [FACTOR_W-1:0] k_q;
  logic                out_valid_q;
  logic [PIX_W-1:0]    out_pixel_q;
  logic                run_last_q;
  logic                out_row_end_q;
  logic                out_frame_end_q;

  logic                  accept;
  logic                  row_last_in;
  logic                  out_free;
  logic                  out_load;
  logic                  last_k;
  logic [FACTOR_W-1:0]   factor_m1;
  logic [PIX_W:0]        diff;
  logic [FACTOR_W:0]     r_sum;
  logic                  carry;
  logic [FACTOR_W-1:0]   r_next;
  logic signed [PIX_W+1:0] q_sum;
  logic [PIX_W:0]        quot_ext;

  always_comb begin
    accept      = in_valid_i && (state_q == ST_IDLE);
    row_last_in = row_end_i || frame_end_i;
    out_free    = !out_valid_q || out_ready_i;
    out_load    = out_free && ((state_q == ST_INTERP) || (state_q == ST_REPEAT));
    factor_m1   = factor_i - FACTOR_W'(1);
    last_k      = (k_q == factor_m1);
    diff        = {1'b0, pixel_value_i} - {1'b0, held_q};
    // remainder / quotient accumulator step
    r_sum  = {1'b0, r_q} + {1'b0, rd_q};
    carry  = (r_sum >= {1'b0, factor_i});
    r_next = carry ? FACTOR_W'(r_sum - {1'b0, factor_i}) : r_sum[FACTOR_W-1:0];
    q_sum  = $signed({2'b00, q_q}) + $signed({qd_q[PIX_W], qd_q})
           + $signed({{(PIX_W+1){1'b0}}, carry});
    quot_ext = {1'b0, div_res_i.quot};
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign div_start_o    = accept && held_valid_q;
  assign div_dividend_o = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      held_q          <= '0;
      held_valid_q    <= 1'b0;
      out_valid_q     <= 1'b0;
      pix_q           <= '0;
      row_last_q      <= 1'b0;
      frame_last_q    <= 1'b0;
      neg_q           <= 1'b0;
      qd_q            <= '0;
      rd_q            <= '0;
      q_q             <= '0;
      r_q             <= '0;
      k_q             <= '0;
      out_pixel_q     <= '0;
      run_last_q      <= 1'b0;
      out_row_end_q   <= 1'b0;
      out_frame_end_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pix_q        <= pixel_value_i;
            row_last_q   <= row_last_in;
            frame_last_q <= frame_end_i;
            neg_q        <= diff[PIX_W];
            k_q          <= '0;
            if (held_valid_q) begin
              state_q <= ST_DIV;
            end else if (row_last_in) begin
              state_q <= ST_REPEAT;
            end else begin
              held_q       <= pixel_value_i;
              held_valid_q <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (div_done_i) begin
            // floor division of a signed difference
            if (!neg_q) begin
              qd_q <= $signed(quot_ext);
              rd_q <= div_res_i.rem;
            end else if (div_res_i.rem == '0) begin
              qd_q <= $signed(~quot_ext + (PIX_W+1)'(1));
              rd_q <= '0;
            end else begin
              qd_q <= $signed(~quot_ext);
              rd_q <= factor_i - div_res_i.rem;
            end
            q_q     <= held_q;
            r_q     <= '0;
            k_q     <= '0;
            state_q <= ST_INTERP;
          end
        end
        ST_INTERP: begin
          if (out_free) begin
            out_pixel_q     <= q_q;
            run_last_q      <= last_k && !row_last_q;
            out_row_end_q   <= 1'b0;
            out_frame_end_q <= 1'b0;
            if (last_k) begin
              k_q <= '0;
              if (row_last_q) begin
                held_q       <= '0;
                held_valid_q <= 1'b0;
                state_q      <= ST_REPEAT;
              end else begin
                held_q  <= pix_q;
                state_q <= ST_IDLE;
              end
            end else begin
              k_q <= k_q + FACTOR_W'(1);
              q_q <= q_sum[PIX_W-1:0];
              r_q <= r_next;
            end
          end
        end
        ST_REPEAT: begin
          if (out_free) begin
            out_pixel_q     <= pix_q;
            run_last_q      <= last_k;
            out_row_end_q   <= last_k;
            out_frame_end_q <= last_k && frame_last_q;
            if (last_k) begin
              held_q       <= '0;
              held_valid_q <= 1'b0;
              state_q      <= ST_IDLE;
            end else begin
              k_q <= k_q + FACTOR_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_pixel_o     = out_pixel_q;
  assign run_last_o      = run_last_q;
  assign out_row_end_o   = out_row_end_q;
  assign out_frame_end_o = out_frame_end_q;

endmodule
